// ===== hw/rtl/cop_pkg.sv =====
// Shared package for the charset odometer phrase generator.
// Holds function codes, register indexes, defaults and control/status types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cop_pkg;

  localparam int unsigned MAX_LEN_DEF       = 16;
  localparam int unsigned CHARSET_DEPTH_DEF = 256;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned LENF_W     = 5;
  localparam int unsigned POSF_W     = 4;
  localparam int unsigned SIZE_W     = 9;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 2'd2;

  localparam logic [LENF_W-1:0] MIN_LENGTH_RST   = 5'd1;
  localparam logic [LENF_W-1:0] MAX_LENGTH_RST   = 5'd8;
  localparam logic [SIZE_W-1:0] CHARSET_SIZE_RST = 9'd62;

  typedef struct packed {
    logic charset_wr;
    logic restart;
    logic issue;
    logic issue_exh;
    logic issue_last;
    logic step;
  } cop_cmd_t;

  typedef struct packed {
    logic issue_ok;
    logic more;
    logic wrap;
  } cop_sts_t;

endpackage

// ===== hw/rtl/charset_odometer_phrase_generator_top.sv =====
// Top level of the charset odometer phrase generator.
// Joins the controller cop_ctrl and the datapath cop_dp; depends on cop_pkg.
//
// Input items arrive on a valid/ready channel with func_i, charset_slot_i and
// charset_byte_i. A charset write or a restart yields no transaction on the
// output. A next-phrase request of length L yields L output transactions, one
// character each, leftmost first, with last_o on the final one; when the search
// is exhausted it yields a single transaction with exhausted_o and last_o high
// and the other fields zero.
// An accepted request moves the controller into its emit state; each character
// then passes through the first result stage, where the charset is read, into
// the output register, and characters are issued one per cycle while the
// staging register can move on. After the last character has been issued the
// odometer carry walks one digit per cycle from the rightmost digit.
// A stalled receiver holds the output register; the block keeps issuing into
// a single staging register and then waits until the output drains.
// Reset sets the length to one, clears all digits and restores the default
// registers; the charset memory holds nothing defined until it is written.
// Configuration writes take effect at once; the user must make them only while
// the block is idle, and the block itself does not enforce this.
`timescale 1ns / 1ps

module charset_odometer_phrase_generator_top #(
  parameter int unsigned MAX_LEN       = cop_pkg::MAX_LEN_DEF,
  parameter int unsigned CHARSET_DEPTH = cop_pkg::CHARSET_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cop_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cop_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cop_pkg::FUNC_W-1:0]      func_i,
  input  logic [cop_pkg::BYTE_W-1:0]      charset_slot_i,
  input  logic [cop_pkg::BYTE_W-1:0]      charset_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cop_pkg::BYTE_W-1:0]      phrase_char_o,
  output logic [cop_pkg::POSF_W-1:0]      char_position_o,
  output logic [cop_pkg::LENF_W-1:0]      phrase_length_o,
  output logic                            last_o,
  output logic                            exhausted_o
);
  import cop_pkg::*;

  localparam int unsigned POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);

  cop_cmd_t         cmd;
  cop_sts_t         sts;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] len;

  cop_ctrl #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W),
    .LEN_W   (LEN_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .len_i      (len),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .pos_o      (pos)
  );

  cop_dp #(
    .MAX_LEN       (MAX_LEN),
    .CHARSET_DEPTH (CHARSET_DEPTH),
    .POS_W         (POS_W),
    .LEN_W         (LEN_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .charset_slot_i  (charset_slot_i),
    .charset_byte_i  (charset_byte_i),
    .cmd_i           (cmd),
    .pos_i           (pos),
    .sts_o           (sts),
    .len_o           (len),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .phrase_char_o   (phrase_char_o),
    .char_position_o (char_position_o),
    .phrase_length_o (phrase_length_o),
    .last_o          (last_o),
    .exhausted_o     (exhausted_o)
  );

endmodule

// ===== hw/rtl/cop_ctrl.sv =====
// Controller state machine of the charset odometer phrase generator.
// Sequences character emission and the odometer carry; drives cop_dp.
// Depends on cop_pkg.
`timescale 1ns / 1ps

module cop_ctrl #(
  parameter int unsigned MAX_LEN = cop_pkg::MAX_LEN_DEF,
  parameter int unsigned POS_W   = 4,
  parameter int unsigned LEN_W   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cop_pkg::FUNC_W-1:0]  func_i,
  input  logic [LEN_W-1:0]            len_i,
  input  cop_pkg::cop_sts_t           sts_i,
  output cop_pkg::cop_cmd_t           cmd_o,
  output logic [POS_W-1:0]            pos_o
);
  import cop_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_EXH   = 2'd2;
  localparam logic [1:0] ST_CARRY = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;
  logic             at_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign at_last    = (LEN_W'(pos_q) == (len_i - LEN_W'(1)));
  assign pos_o      = pos_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_WRITE: cmd_o.charset_wr = 1'b1;
            FUNC_RESTART: cmd_o.restart = 1'b1;
            FUNC_NEXT: begin
              pos_d   = '0;
              state_d = sts_i.more ? ST_EMIT : ST_EXH;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (sts_i.issue_ok) begin
          cmd_o.issue      = 1'b1;
          cmd_o.issue_last = at_last;
          if (at_last) begin
            state_d = ST_CARRY;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      ST_EXH: begin
        if (sts_i.issue_ok) begin
          cmd_o.issue      = 1'b1;
          cmd_o.issue_exh  = 1'b1;
          cmd_o.issue_last = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CARRY: begin
        cmd_o.step = 1'b1;
        if (!sts_i.wrap || (pos_q == '0)) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q - POS_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/cop_dp.sv =====
// Datapath of the charset odometer phrase generator: configuration registers,
// digit registers, charset memory and the two-stage result pipeline.
// Depends on cop_pkg; commanded by cop_ctrl.
`timescale 1ns / 1ps

module cop_dp #(
  parameter int unsigned MAX_LEN       = cop_pkg::MAX_LEN_DEF,
  parameter int unsigned CHARSET_DEPTH = cop_pkg::CHARSET_DEPTH_DEF,
  parameter int unsigned POS_W         = 4,
  parameter int unsigned LEN_W         = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cop_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cop_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [cop_pkg::BYTE_W-1:0]      charset_slot_i,
  input  logic [cop_pkg::BYTE_W-1:0]      charset_byte_i,
  input  cop_pkg::cop_cmd_t               cmd_i,
  input  logic [POS_W-1:0]                pos_i,
  output cop_pkg::cop_sts_t               sts_o,
  output logic [LEN_W-1:0]                len_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cop_pkg::BYTE_W-1:0]      phrase_char_o,
  output logic [cop_pkg::POSF_W-1:0]      char_position_o,
  output logic [cop_pkg::LENF_W-1:0]      phrase_length_o,
  output logic                            last_o,
  output logic                            exhausted_o
);
  import cop_pkg::*;

  localparam int unsigned EW = (LEN_W > LENF_W) ? LEN_W : LENF_W;
  localparam int unsigned AW = $clog2(CHARSET_DEPTH);
  localparam logic [EW-1:0]     MAX_LEN_E = EW'(MAX_LEN);
  localparam logic [SIZE_W-1:0] DEPTH_E   = SIZE_W'(CHARSET_DEPTH);

  logic [LENF_W-1:0] min_length_q, max_length_q;
  logic [SIZE_W-1:0] charset_size_q;

  logic [EW-1:0]     min_ext, max_ext, min_eff, max_eff;
  logic [SIZE_W-1:0] size_eff;

  logic [BYTE_W-1:0] digit_q [MAX_LEN];
  logic [MAX_LEN-1:0] digit_vld_q;
  logic [LEN_W-1:0]   len_q;
  logic               more_q;

  logic [BYTE_W-1:0] charset_mem [CHARSET_DEPTH];

  logic [BYTE_W-1:0] dig;
  logic [SIZE_W-1:0] dig_inc;
  logic              wrap;
  logic [LEN_W-1:0]  len_inc;

  logic              s1_vld_q;
  logic              s1_exh_q, s1_oor_q, s1_last_q;
  logic [POSF_W-1:0] s1_pos_q;
  logic [LENF_W-1:0] s1_len_q;
  logic [BYTE_W-1:0] rd_q;
  logic              s1_move, issue_ok;
  logic              o_vld_q;

  assign min_ext  = EW'(min_length_q);
  assign max_ext  = EW'(max_length_q);
  assign min_eff  = (min_ext == '0) ? EW'(1) : ((min_ext > MAX_LEN_E) ? MAX_LEN_E : min_ext);
  assign max_eff  = (max_ext > MAX_LEN_E) ? MAX_LEN_E : max_ext;
  assign size_eff = (charset_size_q == '0) ? SIZE_W'(1)
                  : ((charset_size_q > DEPTH_E) ? DEPTH_E : charset_size_q);

  assign dig     = digit_vld_q[pos_i] ? digit_q[pos_i] : '0;
  assign dig_inc = SIZE_W'(dig) + SIZE_W'(1);
  assign wrap    = (dig_inc >= size_eff);
  assign len_inc = len_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q   <= MIN_LENGTH_RST;
      max_length_q   <= MAX_LENGTH_RST;
      charset_size_q <= CHARSET_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LENGTH:   min_length_q   <= cfg_wdata_i[LENF_W-1:0];
        CFG_MAX_LENGTH:   max_length_q   <= cfg_wdata_i[LENF_W-1:0];
        CFG_CHARSET_SIZE: charset_size_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_vld_q <= '0;
      len_q       <= LEN_W'(1);
      more_q      <= 1'b1;
    end else begin
      if (cmd_i.restart) begin
        digit_vld_q <= '0;
        len_q       <= min_eff[LEN_W-1:0];
        more_q      <= (min_eff <= max_eff);
      end else if (cmd_i.step) begin
        if (wrap && (pos_i == '0)) begin
          len_q <= len_inc;
          if (EW'(len_inc) > max_eff) begin
            digit_vld_q[pos_i] <= 1'b1;
            more_q             <= 1'b0;
          end else begin
            digit_vld_q <= '0;
          end
        end else begin
          digit_vld_q[pos_i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      digit_q[pos_i] <= wrap ? '0 : dig_inc[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.charset_wr && (SIZE_W'(charset_slot_i) < DEPTH_E)) begin
      charset_mem[charset_slot_i[AW-1:0]] <= charset_byte_i;
    end
    if (cmd_i.issue && !cmd_i.issue_exh) begin
      rd_q <= charset_mem[dig[AW-1:0]];
    end
  end

  assign s1_move  = s1_vld_q && (!o_vld_q || out_ready_i);
  assign issue_ok = !s1_vld_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        o_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_exh_q  <= cmd_i.issue_exh;
      s1_last_q <= cmd_i.issue_last;
      s1_oor_q  <= (SIZE_W'(dig) >= DEPTH_E);
      s1_pos_q  <= cmd_i.issue_exh ? '0 : POSF_W'(pos_i);
      s1_len_q  <= cmd_i.issue_exh ? '0 : LENF_W'(len_q);
    end
    if (s1_move) begin
      phrase_char_o   <= (s1_exh_q || s1_oor_q) ? '0 : rd_q;
      char_position_o <= s1_pos_q;
      phrase_length_o <= s1_len_q;
      last_o          <= s1_last_q;
      exhausted_o     <= s1_exh_q;
    end
  end

  assign out_valid_o    = o_vld_q;
  assign len_o          = len_q;
  assign sts_o.issue_ok = issue_ok;
  assign sts_o.more     = more_q;
  assign sts_o.wrap     = wrap;

endmodule

// ===== verif/charset_odometer_phrase_generator_top_tb.sv =====
// Self-checking testbench for charset_odometer_phrase_generator_top.
// A scoreboard class predicts each output transaction from the accepted inputs and the
// register settings; depends on cop_pkg and the top-level RTL.
`timescale 1ns / 1ps

import cop_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] ch;
  logic [POSF_W-1:0] pos;
  logic [LENF_W-1:0] len;
  logic              last;
  logic              exh;
} phrase_result_t;

class phrase_scoreboard;
  logic [LENF_W-1:0] min_len;
  logic [LENF_W-1:0] max_len;
  logic [SIZE_W-1:0] cs_size;
  logic [BYTE_W-1:0] digit [MAX_LEN_DEF];
  logic [BYTE_W-1:0] charset [CHARSET_DEPTH_DEF];
  int unsigned       cur_len;
  bit                more;
  phrase_result_t    expected_chars [$];
  int unsigned       errors;

  function new();
    min_len = MIN_LENGTH_RST;
    max_len = MAX_LENGTH_RST;
    cs_size = CHARSET_SIZE_RST;
    foreach (charset[i]) charset[i] = '0;
    clear_digits();
    cur_len = 1;
    more    = 1'b1;
    errors  = 0;
  endfunction

  function void clear_digits();
    foreach (digit[i]) digit[i] = '0;
  endfunction

  function int unsigned eff_min();
    if (min_len == 0) return 1;
    if (min_len > MAX_LEN_DEF) return MAX_LEN_DEF;
    return 32'(min_len);
  endfunction

  function int unsigned eff_max();
    if (max_len > MAX_LEN_DEF) return MAX_LEN_DEF;
    return 32'(max_len);
  endfunction

  function int unsigned eff_size();
    if (cs_size == 0) return 1;
    if (cs_size > CHARSET_DEPTH_DEF) return CHARSET_DEPTH_DEF;
    return 32'(cs_size);
  endfunction

  function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MIN_LENGTH:   min_len = data[LENF_W-1:0];
      CFG_MAX_LENGTH:   max_len = data[LENF_W-1:0];
      CFG_CHARSET_SIZE: cs_size = data[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function void restart_search();
    clear_digits();
    cur_len = eff_min();
    more    = (cur_len <= eff_max());
  endfunction

  // The rightmost digit is the least significant one.
  function void advance_digits();
    int unsigned cs;
    int unsigned i;
    int unsigned d;
    cs = eff_size();
    i  = cur_len;
    while (i > 0) begin
      i--;
      d = 32'(digit[i]) + 1;
      if (d < cs) begin
        digit[i] = d[BYTE_W-1:0];
        return;
      end
      digit[i] = '0;
    end
    cur_len++;
    if (cur_len > eff_max()) begin
      more = 1'b0;
      return;
    end
    clear_digits();
  endfunction

  function void note_input(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] slot,
                           logic [BYTE_W-1:0] data);
    phrase_result_t r;
    int unsigned    j;
    if (func == FUNC_WRITE) begin
      charset[slot] = data;
    end else if (func == FUNC_RESTART) begin
      restart_search();
    end else if (func == FUNC_NEXT) begin
      if (!more || cur_len == 0 || cur_len > MAX_LEN_DEF) begin
        r      = '0;
        r.last = 1'b1;
        r.exh  = 1'b1;
        expected_chars.push_back(r);
      end else begin
        for (j = 0; j < cur_len; j++) begin
          r.ch   = charset[digit[j]];
          r.pos  = j[POSF_W-1:0];
          r.len  = cur_len[LENF_W-1:0];
          r.last = (j + 1 == cur_len);
          r.exh  = 1'b0;
          expected_chars.push_back(r);
        end
        advance_digits();
      end
    end
  endfunction

  function void check_result(phrase_result_t act);
    phrase_result_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected output transaction: phrase_char %0d char_position %0d", act.ch,
             act.pos);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    if (act.ch !== want.ch) begin
      $error("phrase_char: expected %0d, actual %0d", want.ch, act.ch);
      errors++;
    end
    if (act.pos !== want.pos) begin
      $error("char_position: expected %0d, actual %0d", want.pos, act.pos);
      errors++;
    end
    if (act.len !== want.len) begin
      $error("phrase_length: expected %0d, actual %0d", want.len, act.len);
      errors++;
    end
    if (act.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, act.last);
      errors++;
    end
    if (act.exh !== want.exh) begin
      $error("exhausted: expected %0d, actual %0d", want.exh, act.exh);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_chars.size();
  endfunction
endclass

module charset_odometer_phrase_generator_top_tb;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned SETTLE       = 2 * MAX_LEN_DEF + 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned LOADED_SLOTS = 32;
  localparam int unsigned PASS_ITEMS   = 20;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i          = '0;
  logic [BYTE_W-1:0]     charset_slot_i  = '0;
  logic [BYTE_W-1:0]     charset_byte_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [BYTE_W-1:0]     phrase_char_o;
  logic [POSF_W-1:0]     char_position_o;
  logic [LENF_W-1:0]     phrase_length_o;
  logic                  last_o;
  logic                  exhausted_o;

  phrase_scoreboard sb;
  int unsigned      in_idle_pct  = 30;
  int unsigned      out_idle_pct = 30;
  int unsigned      cycle_count  = 0;

  always #5 clk_i = ~clk_i;

  charset_odometer_phrase_generator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .charset_slot_i  (charset_slot_i),
    .charset_byte_i  (charset_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .phrase_char_o   (phrase_char_o),
    .char_position_o (char_position_o),
    .phrase_length_o (phrase_length_o),
    .last_o          (last_o),
    .exhausted_o     (exhausted_o)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({phrase_char_o, char_position_o, phrase_length_o, last_o, exhausted_o});
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_ready_i = 1'b0;
        hold = $urandom_range(4);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] slot,
                           input logic [BYTE_W-1:0] data);
    @(negedge clk_i);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    func_i         = func;
    charset_slot_i = slot;
    charset_byte_i = data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(func, slot, data);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.apply_register(idx, data);
  endtask

  task automatic configure(input int unsigned min_v, input int unsigned max_v,
                           input int unsigned size_v);
    drain();
    write_reg(CFG_MIN_LENGTH, min_v[CFG_DATA_W-1:0]);
    write_reg(CFG_MAX_LENGTH, max_v[CFG_DATA_W-1:0]);
    write_reg(CFG_CHARSET_SIZE, size_v[CFG_DATA_W-1:0]);
  endtask

  task automatic next_phrases(input int unsigned n);
    repeat (n) send_item(FUNC_NEXT, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) send_item(FUNC_NEXT, BYTE_W'($urandom), BYTE_W'($urandom));
    else if (r < 82) send_item(FUNC_WRITE, BYTE_W'($urandom), BYTE_W'($urandom));
    else if (r < 94) send_item(FUNC_RESTART, BYTE_W'($urandom), BYTE_W'($urandom));
    else send_item(FUNC_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  initial begin
    int unsigned i;
    int unsigned p;
    int unsigned k;
    int unsigned min_v;
    int unsigned max_v;
    int unsigned size_v;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The low table entries are loaded first. Between restarts no digit climbs past
    // them, so no request ever reads an unwritten entry.
    for (i = 0; i < LOADED_SLOTS; i++) begin
      send_item(FUNC_WRITE, i[BYTE_W-1:0], BYTE_W'($urandom));
    end

    send_item(FUNC_WRITE, 8'h00, 8'hFF);
    send_item(FUNC_WRITE, 8'hFF, 8'h00);
    next_phrases(2);
    send_item(FUNC_UNUSED, 8'hFF, 8'hFF);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(1);

    // A zero minimum acts as one; a single character forces growth on every request until the search is exhausted.
    configure(0, 2, 1);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(4);

    // Out-of-range values clamp to the largest phrase and a single character.
    configure(31, 31, 0);
    write_reg(CFG_UNUSED, 9'h1FF);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(2);

    // A maximum below the minimum exhausts the search at once.
    configure(3, 2, 2);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(1);
    configure(1, 0, 5);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(1);

    // The charset size and then the maximum are lowered in the middle of a run.
    configure(2, 4, 300);
    send_item(FUNC_RESTART, 8'h00, 8'h00);
    next_phrases(3);
    drain();
    write_reg(CFG_CHARSET_SIZE, 9'd2);
    next_phrases(2);
    drain();
    write_reg(CFG_MAX_LENGTH, 9'd2);
    next_phrases(5);

    for (p = 0; p < 6; p++) begin
      min_v  = ($urandom_range(99) < 50) ? $urandom_range(3, 1) : $urandom_range(31, 0);
      max_v  = ($urandom_range(99) < 60) ? $urandom_range(5, 1) : $urandom_range(31, 0);
      k      = $urandom_range(99);
      size_v = (k < 60) ? $urandom_range(4, 1) : (k < 80) ? $urandom_range(511, 0) : 256;
      configure(min_v, max_v, size_v);
      if (p == 5 || p == 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 30;
        out_idle_pct = 30;
      end
      send_item(FUNC_RESTART, BYTE_W'($urandom), BYTE_W'($urandom));
      for (k = 0; k < PASS_ITEMS; k++) begin
        random_item();
        if (p == 2 && k == 15) wait_for_results();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
